/* rtl/quad_encoder_detent_decoder_unit_assert.svh */
// Assertion macros for the quadrature detent decoder.
// Used by the top level only; no dependencies.
`ifndef QUAD_ENCODER_DETENT_DECODER_UNIT_ASSERT_SVH
`define QUAD_ENCODER_DETENT_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define QEDD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define QEDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QEDD_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define QEDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/qedd_pkg.sv */
// Shared types, widths and the Gray-code step table for the detent decoder.
// No dependencies.
package qedd_pkg;

  localparam int NUM_ENC_MAX = 4;
  localparam int PIN_W       = 16;
  localparam int FLAG_W      = 8;
  localparam int MASK_W      = 4;
  localparam int DIV_W       = 7;
  localparam int CNT_W       = 8;
  localparam int IDX_W       = 2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_ENABLE_MASK    = 2'd0;
  localparam logic [IDX_W-1:0] REG_INVERT_MASK    = 2'd1;
  localparam logic [IDX_W-1:0] REG_DETENT_DIVISOR = 2'd2;

  localparam logic [DIV_W-1:0] DIVISOR_RESET = 7'd4;

  typedef logic [1:0]              pair_t;
  typedef logic signed [1:0]       step_t;
  typedef logic signed [CNT_W-1:0] cnt_t;

  // Per-lane detent result
  typedef struct packed {
    logic ccw;
    logic cw;
  } lane_res_t;

  // Step per {before, after}: +1, -1, or 0 for no change / invalid jump
  localparam step_t GRAY_STEP [16] = '{
    2'sd0, -2'sd1,  2'sd1,  2'sd0,
    2'sd1,  2'sd0,  2'sd0, -2'sd1,
   -2'sd1,  2'sd0,  2'sd0,  2'sd1,
    2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

endpackage

/* rtl/qedd_lane.sv */
// One encoder lane: pin swap, Gray-code step, signed sub-count and detent test.
// Depends on qedd_pkg.
module qedd_lane (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fire,
  input  logic                      en,
  input  logic                      inv,
  input  qedd_pkg::pair_t           prior,
  input  qedd_pkg::pair_t           after,
  input  logic [qedd_pkg::DIV_W-1:0] divisor,
  output qedd_pkg::lane_res_t       res
);
  import qedd_pkg::*;

  cnt_t                     count;
  cnt_t                     count_next;
  pair_t                    pb;
  pair_t                    pa;
  logic                     active;
  step_t                    step;
  logic signed [CNT_W:0]    sum;
  logic signed [CNT_W:0]    div_pos;
  logic signed [CNT_W:0]    div_neg;

  // optional A/B swap, then table lookup
  always_comb begin
    pb      = inv ? {prior[0], prior[1]} : prior;
    pa      = inv ? {after[0], after[1]} : after;
    active  = fire && en && (pb != pa);
    step    = GRAY_STEP[{pb, pa}];
    sum     = (CNT_W+1)'(count) + (CNT_W+1)'(step);
    div_pos = $signed({2'b00, divisor});
    div_neg = -div_pos;
  end

  // detent compare; a hit clears the sub-count
  always_comb begin
    res.cw     = active && (sum >= div_pos);
    res.ccw    = active && !res.cw && (sum <= div_neg);
    count_next = count;
    if (active) begin
      count_next = (res.cw || res.ccw) ? '0 : sum[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

/* rtl/qedd_merge.sv */
// Merges lane results into the flag word and holds it in an output register
// with a skid stage. Depends on qedd_pkg.
module qedd_merge (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      fire,
  input  qedd_pkg::lane_res_t [qedd_pkg::NUM_ENC_MAX-1:0] lane_res,
  output logic                                      skid_full,
  output logic                                      flags_valid,
  input  logic                                      flags_stall,
  output logic [qedd_pkg::FLAG_W-1:0]               detent_flags
);
  import qedd_pkg::*;

  logic [FLAG_W-1:0] merged;
  logic [FLAG_W-1:0] skid_flags;
  logic              skid_valid;
  logic              out_free;

  // pack lane results: bit 2i clockwise, bit 2i+1 counter-clockwise
  always_comb begin
    for (int i = 0; i < NUM_ENC_MAX; i++) begin
      merged[2*i]   = lane_res[i].cw;
      merged[2*i+1] = lane_res[i].ccw;
    end
  end

  assign out_free  = !flags_valid || !flags_stall;
  assign skid_full = skid_valid;

  // output register and skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      flags_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (out_free) begin
      flags_valid <= skid_valid || fire;
      skid_valid  <= 1'b0;
    end else if (fire) begin
      skid_valid  <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      detent_flags <= skid_valid ? skid_flags : merged;
    end else if (fire) begin
      skid_flags <= merged;
    end
  end

endmodule

/* rtl/quad_encoder_detent_decoder_unit.sv */
// Top level of the quadrature detent decoder: config registers, lanes, merge.
// Depends on qedd_pkg, qedd_lane, qedd_merge and the assertion macro header.
//
// Decodes up to four quadrature encoders from one 16-bit pin sample per
// request: low byte holds each encoder's previous A/B pair, high byte its new
// pair. Every encoder has its own lane with a signed sub-count, so all four are
// updated in the same cycle. Throughput is one pin word per clock while pin_stall
// is low; the lane's single add-and-compare feeds detent_flags through the output
// register, or through the skid entry when the output waits. A two-entry output stage
// (register plus skid) keeps taking words while a result waits, and pin_stall
// rises only when both entries are full. Configuration (enable, invert,
// divisor; a divisor of zero acts as one) must be written while idle.
`include "quad_encoder_detent_decoder_unit_assert.svh"

module quad_encoder_detent_decoder_unit #(
  parameter int NUM_ENCODERS = qedd_pkg::NUM_ENC_MAX
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [qedd_pkg::IDX_W-1:0]    wr_index,
  input  logic [qedd_pkg::DIV_W-1:0]    wr_data,
  input  logic                          pin_valid,
  output logic                          pin_stall,
  input  logic [qedd_pkg::PIN_W-1:0]    pin_word,
  output logic                          flags_valid,
  input  logic                          flags_stall,
  output logic [qedd_pkg::FLAG_W-1:0]   detent_flags
);
  import qedd_pkg::*;

  logic [MASK_W-1:0]                enable_mask;
  logic [MASK_W-1:0]                invert_mask;
  logic [DIV_W-1:0]                 detent_divisor;
  logic [DIV_W-1:0]                 div_eff;
  logic                             fire;
  logic                             skid_full;
  lane_res_t [NUM_ENC_MAX-1:0]      lane_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask    <= '0;
      invert_mask    <= '0;
      detent_divisor <= DIVISOR_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_ENABLE_MASK:    enable_mask    <= wr_data[MASK_W-1:0];
        REG_INVERT_MASK:    invert_mask    <= wr_data[MASK_W-1:0];
        REG_DETENT_DIVISOR: detent_divisor <= wr_data;
        default: ;
      endcase
    end
  end

  assign div_eff   = (detent_divisor == '0) ? DIV_W'(1) : detent_divisor;
  assign pin_stall = skid_full;
  assign fire      = pin_valid && !pin_stall;

  // encoder lanes; unused positions report nothing
  for (genvar i = 0; i < NUM_ENC_MAX; i++) begin : g_lane
    if (i < NUM_ENCODERS) begin : g_on
      qedd_lane u_lane (
        .clk     (clk),
        .rst     (rst),
        .fire    (fire),
        .en      (enable_mask[i]),
        .inv     (invert_mask[i]),
        .prior   (pin_word[2*i+1:2*i]),
        .after   (pin_word[2*i+9:2*i+8]),
        .divisor (div_eff),
        .res     (lane_res[i])
      );
    end else begin : g_off
      assign lane_res[i] = '0;
    end
  end

  qedd_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .lane_res     (lane_res),
    .skid_full    (skid_full),
    .flags_valid  (flags_valid),
    .flags_stall  (flags_stall),
    .detent_flags (detent_flags)
  );

  // checks
  `QEDD_ASSERT_NOW(a_skid_behind_out, clk, rst, pin_stall, flags_valid, "skid full, no output")
  `QEDD_ASSERT_NEXT(a_req_lands, clk, rst, fire, flags_valid, "request produced no result")
  `QEDD_ASSERT_NOW(a_one_dir, clk, rst, flags_valid, ((detent_flags & (detent_flags >> 1) & 8'h55) == 8'h00), "both directions")

endmodule

/* verif/qedd_detent_checker.sv */
// Checker for the quadrature detent decoder: predicts detent flags per request.
// Watches the config port and both channels. Depends on qedd_pkg.
module qedd_detent_checker
  import qedd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [DIV_W-1:0]  wr_data,
  input  logic              pin_valid,
  input  logic              pin_stall,
  input  logic [PIN_W-1:0]  pin_word,
  input  logic              flags_valid,
  input  logic              flags_stall,
  input  logic [FLAG_W-1:0] detent_flags,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predictor state: per-encoder sub-counts and the config copy
  cnt_t              enc_count [NUM_ENC_MAX];
  logic [MASK_W-1:0] enc_enable;
  logic [MASK_W-1:0] enc_swap;
  logic [DIV_W-1:0]  steps_per_detent;
  logic [FLAG_W-1:0] expected_flags [$];

  // Position along the clockwise Gray sequence 00 -> 10 -> 11 -> 01
  function automatic logic [1:0] gray_pos(input pair_t p);
    case (p)
      2'b00:   return 2'd0;
      2'b10:   return 2'd1;
      2'b11:   return 2'd2;
      default: return 2'd3;
    endcase
  endfunction

  // Advance every enabled encoder by one pin sample, return its detent flags
  function automatic logic [FLAG_W-1:0] predict_detents(input logic [PIN_W-1:0] word);
    logic [FLAG_W-1:0] flags;
    pair_t             prev_ab;
    pair_t             next_ab;
    logic [1:0]        moved;
    int                limit;
    int                acc;
    flags = '0;
    limit = (steps_per_detent == 0) ? 1 : int'(steps_per_detent);
    for (int i = 0; i < NUM_ENC_MAX; i++) begin
      prev_ab = word[2*i +: 2];
      next_ab = word[8 + 2*i +: 2];
      if (enc_enable[i]) begin
        if (enc_swap[i]) begin
          prev_ab = {prev_ab[0], prev_ab[1]};
          next_ab = {next_ab[0], next_ab[1]};
        end
        // unchanged pair: no step, no compare
        if (prev_ab != next_ab) begin
          acc   = int'(enc_count[i]);
          moved = gray_pos(next_ab) - gray_pos(prev_ab);
          if (moved == 2'd1) acc = acc + 1;
          else if (moved == 2'd3) acc = acc - 1;
          // a double-bit jump adds nothing but is still compared
          if (acc >= limit) begin
            flags[2*i] = 1'b1;
            acc = 0;
          end else if (acc <= -limit) begin
            flags[2*i+1] = 1'b1;
            acc = 0;
          end
          enc_count[i] = cnt_t'(acc);
        end
      end
    end
    return flags;
  endfunction

  always @(posedge clk) begin : monitor
    logic [FLAG_W-1:0] want;
    if (rst) begin
      for (int i = 0; i < NUM_ENC_MAX; i++) enc_count[i] = '0;
      enc_enable       = '0;
      enc_swap         = '0;
      steps_per_detent = DIVISOR_RESET;
      expected_flags.delete();
      errors = 0;
    end else begin
      // config writes must land only while idle, which the DUT does not enforce; then order against requests is moot
      if (wr_en) begin
        case (wr_index)
          REG_ENABLE_MASK:    enc_enable       = wr_data[MASK_W-1:0];
          REG_INVERT_MASK:    enc_swap         = wr_data[MASK_W-1:0];
          REG_DETENT_DIVISOR: steps_per_detent = wr_data;
          default: ;
        endcase
      end
      if (pin_valid && !pin_stall) expected_flags.push_back(predict_detents(pin_word));
      if (flags_valid && !flags_stall) begin
        if (expected_flags.size() == 0) begin
          $error("detent_flags: no request outstanding, expected none, actual %h",
                 detent_flags);
          errors++;
        end else begin
          want = expected_flags.pop_front();
          if (detent_flags !== want) begin
            $error("detent_flags mismatch: expected %h, actual %h", want, detent_flags);
            errors++;
          end
        end
      end
    end
    pending = expected_flags.size();
  end

endmodule

/* verif/tb_quad_encoder_detent_decoder_unit.sv */
// Testbench top for the quadrature detent decoder: clock, reset, config
// writes, pin-word requests and result stalls. Depends on qedd_pkg and qedd_detent_checker.
module tb_quad_encoder_detent_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import qedd_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index, writes ignored
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 150;
  localparam int NUM_PHASES  = 10;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              wr_en        = 1'b0;
  logic [IDX_W-1:0]  wr_index     = '0;
  logic [DIV_W-1:0]  wr_data      = '0;
  logic              pin_valid    = 1'b0;
  logic              pin_stall;
  logic [PIN_W-1:0]  pin_word     = '0;
  logic              flags_valid;
  logic              flags_stall  = 1'b0;
  logic [FLAG_W-1:0] detent_flags;
  int                errors;
  int                pending;
  logic              quiet        = 1'b0;
  int                stall_left   = 0;
  pair_t             shaft [NUM_ENC_MAX];

  initial begin
    forever #6 clk = ~clk;
  end

  quad_encoder_detent_decoder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .pin_valid    (pin_valid),
    .pin_stall    (pin_stall),
    .pin_word     (pin_word),
    .flags_valid  (flags_valid),
    .flags_stall  (flags_stall),
    .detent_flags (detent_flags)
  );

  qedd_detent_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .pin_valid    (pin_valid),
    .pin_stall    (pin_stall),
    .pin_word     (pin_word),
    .flags_valid  (flags_valid),
    .flags_stall  (flags_stall),
    .detent_flags (detent_flags),
    .errors       (errors),
    .pending      (pending)
  );

  // Result-side backpressure in random bursts
  always @(negedge clk) begin
    if (quiet) begin
      flags_stall <= 1'b0;
    end else if (stall_left > 0) begin
      flags_stall <= 1'b1;
      stall_left  = stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      flags_stall <= 1'b1;
      stall_left  = $urandom_range(1, 7) - 1;
    end else begin
      flags_stall <= 1'b0;
    end
  end

  // Watchdog: ends the run after too long with no handshake on either side
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((pin_valid && !pin_stall) || (flags_valid && !flags_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIV_W-1:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(negedge clk);
    wr_en    <= 1'b0;
  endtask

  // One request, with an optional random gap ahead of it
  task automatic send_word(input logic [PIN_W-1:0] w);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      pin_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pin_valid <= 1'b1;
    pin_word  <= w;
    @(posedge clk);
    while (pin_stall) @(posedge clk);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk);
    pin_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Same transition on all four encoders
  function automatic logic [PIN_W-1:0] all_lanes(input pair_t prev_ab, input pair_t next_ab);
    return {{4{next_ab}}, {4{prev_ab}}};
  endfunction

  // Neighbor along the clockwise Gray sequence 00 -> 10 -> 11 -> 01, or back
  function automatic pair_t gray_neighbor(input pair_t p, input bit cw);
    case (p)
      2'b00:   return cw ? 2'b10 : 2'b01;
      2'b10:   return cw ? 2'b11 : 2'b00;
      2'b11:   return cw ? 2'b01 : 2'b10;
      default: return cw ? 2'b00 : 2'b11;
    endcase
  endfunction

  // One config setting, then mostly well-formed rotation with some noise
  task automatic run_phase(input int n, input logic [MASK_W-1:0] en,
                           input logic [MASK_W-1:0] inv, input logic [DIV_W-1:0] div);
    logic [PIN_W-1:0] w;
    pair_t            nxt;
    bit               cw;
    int               r;
    write_reg(REG_ENABLE_MASK, {3'($urandom_range(0, 7)), en});
    write_reg(REG_INVERT_MASK, {3'($urandom_range(0, 7)), inv});
    write_reg(REG_DETENT_DIVISOR, div);
    cw = $urandom_range(0, 1);
    for (int k = 0; k < n; k++) begin
      if (k == n / 2 && !quiet) wait_drained();
      if ($urandom_range(0, 99) < 15) begin
        w = PIN_W'($urandom);
      end else begin
        for (int i = 0; i < NUM_ENC_MAX; i++) begin
          r = $urandom_range(0, 99);
          if (r < 55) nxt = gray_neighbor(shaft[i], cw ^ i[0]);
          else if (r < 65) nxt = gray_neighbor(shaft[i], !(cw ^ i[0]));
          else if (r < 80) nxt = shaft[i];
          else if (r < 90) nxt = ~shaft[i];  // illegal double-bit jump
          else nxt = pair_t'($urandom_range(0, 3));
          w[2*i +: 2]     = shaft[i];
          w[8 + 2*i +: 2] = nxt;
          shaft[i] = nxt;
        end
      end
      send_word(w);
    end
    wait_drained();
  endtask

  initial begin : stimulus
    logic [3:0] t;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset config: every encoder disabled, flags stay clear
    send_word(16'hB4E1);
    send_word(16'hFF00);
    wait_drained();

    // Every transition on all encoders, one step per detent, mask upper bits set
    write_reg(REG_ENABLE_MASK, {3'b111, 4'hF});
    write_reg(REG_INVERT_MASK, '0);
    write_reg(REG_DETENT_DIVISOR, 7'd1);
    write_reg(REG_SPARE, 7'h55);
    for (int j = 0; j < 16; j++) begin
      t = 4'(j);
      send_word(all_lanes(t[3:2], t[1:0]));
    end
    wait_drained();

    // Swapped pins and a zero divisor (acts as one)
    write_reg(REG_INVERT_MASK, 7'h0F);
    write_reg(REG_DETENT_DIVISOR, 7'd0);
    send_word(all_lanes(2'b00, 2'b10));
    send_word(all_lanes(2'b10, 2'b11));
    send_word(all_lanes(2'b11, 2'b01));
    send_word(all_lanes(2'b01, 2'b00));
    wait_drained();

    // Random phases across settings, extremes included; last one without idling
    for (int i = 0; i < NUM_ENC_MAX; i++) shaft[i] = 2'b00;
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiet = (p == NUM_PHASES - 1);
      case (p)
        0: run_phase(PHASE_ITEMS, 4'hF, 4'h0, 7'd4);
        1: run_phase(PHASE_ITEMS, 4'hF, 4'hF, 7'd2);
        2: run_phase(PHASE_ITEMS, 4'h5, 4'hA, 7'd0);
        3: run_phase(PHASE_ITEMS, 4'hF, 4'($urandom_range(0, 15)), 7'd1);
        4: run_phase(PHASE_ITEMS, 4'hF, 4'h3, 7'd64);
        5: run_phase(PHASE_ITEMS, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                     7'd127);
        6: run_phase(PHASE_ITEMS, 4'hF, 4'hC, 7'($urandom_range(1, 64)));
        7: run_phase(PHASE_ITEMS, 4'h0, 4'hF, 7'd3);
        8: run_phase(PHASE_ITEMS, 4'hF, 4'($urandom_range(0, 15)),
                     7'($urandom_range(0, 127)));
        default: run_phase(PHASE_ITEMS, 4'hF, 4'h0, 7'd3);
      endcase
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
